FILE: rtl/core/hmac_sha256_engine_assert.svh
// Assertion macros shared by the engine RTL.
`ifndef HMAC_SHA256_ENGINE_ASSERT_SVH
`define HMAC_SHA256_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on the engine clock.
`define HSE_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("hmac_sha256_engine: assertion failed");

// Next-cycle implication, sampled on the engine clock.
`define HSE_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("hmac_sha256_engine: assertion failed");

`endif

FILE: rtl/core/hse_pkg.sv
`timescale 1ns / 1ps
package hse_pkg;

  typedef struct packed {
    logic       mode;
    logic [7:0] byte_value;
    logic       has_byte;
    logic       last;
  } hse_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } hse_out_t;

  // Commands from the sequencer to the compression core.
  typedef struct packed {
    logic       init;
    logic       put;
    logic       cnt;
    logic [7:0] data;
  } hs_ctl_t;

  typedef struct packed {
    logic       busy;
    logic [5:0] fill;
  } hs_stat_t;

  typedef logic [7:0][31:0] hse_words_t;

  localparam hse_words_t SHA_IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic logic [31:0] rotr(logic [31:0] x, int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  // Byte idx of a digest, big-endian within each word.
  function automatic logic [7:0] dig_byte(hse_words_t w, logic [4:0] idx);
    logic [31:0] wd;
    wd = w[idx[4:2]];
    case (idx[1:0])
      2'd0:    dig_byte = wd[31:24];
      2'd1:    dig_byte = wd[23:16];
      2'd2:    dig_byte = wd[15:8];
      default: dig_byte = wd[7:0];
    endcase
  endfunction

  function automatic logic [31:0] round_k(logic [5:0] i);
    case (i)
      6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
      default: round_k = 32'h0;
    endcase
  endfunction

endpackage

FILE: rtl/core/hmac_sha256_engine.sv
`timescale 1ns / 1ps
// Channel   Direction  Payload     Handshake
// in        input      hse_in_t    in_valid_i / in_stall_o
// out       output     hse_out_t   out_valid_o / out_stall_i
//
// Key bytes up to 64 and message bytes are taken one per cycle when the core is free.
// Each 64-byte block is compressed one round per cycle, followed by the add.
// The padded key block is loaded by reading each byte, then absorbing it, before the hand-off.
// Tag: eight word beats after both final compressions; out_stall_i holds the current word.
// Reset clears control state and the key length; the key memory needs no clearing pass.
module hmac_sha256_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  hse_pkg::hse_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output hse_pkg::hse_out_t out_data_o
);
  import hse_pkg::*;

  `include "hmac_sha256_engine_assert.svh"

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOADK = 3'd1;
  localparam logic [2:0] ST_PUTB  = 3'd2;
  localparam logic [2:0] ST_PAD   = 3'd3;
  localparam logic [2:0] ST_WAITD = 3'd4;
  localparam logic [2:0] ST_KEYW  = 3'd5;
  localparam logic [2:0] ST_INNER = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  localparam logic [2:0] RET_PUTB   = 3'd0;
  localparam logic [2:0] RET_MSG    = 3'd1;
  localparam logic [2:0] RET_INNERB = 3'd2;
  localparam logic [2:0] RET_KEYDIG = 3'd3;
  localparam logic [2:0] RET_INNERD = 3'd4;
  localparam logic [2:0] RET_TAG    = 3'd5;

  localparam logic [1:0] PS_MARK = 2'd0;
  localparam logic [1:0] PS_ZERO = 2'd1;
  localparam logic [1:0] PS_LEN  = 2'd2;

  localparam logic PH_KEY = 1'b0;
  localparam logic PH_MSG = 1'b1;

  logic [2:0] state_q, state_d;
  logic [2:0] ret_q, ret_d;
  logic       phase_q, phase_d;
  logic [6:0] klen_q, klen_d;
  logic       long_q, long_d;
  logic [6:0] cnt_q, cnt_d;
  logic       pend_q, pend_d;
  logic       zero_q, zero_d;
  logic [7:0] xor_q, xor_d;
  logic [1:0] psub_q, psub_d;
  logic [7:0] item_b_q, item_b_d;
  logic       item_last_q, item_last_d;
  hse_words_t inner_q, inner_d;

  logic [7:0] key_mem [64];
  logic       km_we, km_re;
  logic [5:0] km_wa;
  logic [7:0] km_wd, km_rd_q;

  hs_ctl_t     ctl;
  hs_stat_t    stat;
  hse_words_t  h;
  logic [63:0] bits;

  logic in_acc;

  hse_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .stat_o (stat),
    .h_o    (h),
    .bits_o (bits)
  );

  assign in_stall_o = !((state_q == ST_IDLE) && !stat.busy);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    phase_d     = phase_q;
    klen_d      = klen_q;
    long_d      = long_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    zero_d      = zero_q;
    xor_d       = xor_q;
    psub_d      = psub_q;
    item_b_d    = item_b_q;
    item_last_d = item_last_q;
    inner_d     = inner_q;
    ctl         = '0;
    km_we       = 1'b0;
    km_wa       = klen_q[5:0];
    km_wd       = in_data_i.byte_value;
    km_re       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && phase_q == PH_KEY && !in_data_i.mode) begin
          if (in_data_i.has_byte && !long_q && klen_q[6]) begin
            // 65th key byte: hash the buffered key, then this byte
            long_d      = 1'b1;
            ctl.init    = 1'b1;
            item_b_d    = in_data_i.byte_value;
            item_last_d = in_data_i.last;
            cnt_d       = '0;
            pend_d      = 1'b0;
            xor_d       = 8'h00;
            ret_d       = RET_PUTB;
            state_d     = ST_LOADK;
          end else begin
            if (in_data_i.has_byte) begin
              if (long_q) begin
                ctl.put  = 1'b1;
                ctl.cnt  = 1'b1;
                ctl.data = in_data_i.byte_value;
              end else begin
                km_we  = 1'b1;
                klen_d = klen_q + 7'd1;
              end
            end
            if (in_data_i.last) begin
              if (long_q) begin
                psub_d  = PS_MARK;
                ret_d   = RET_KEYDIG;
                state_d = ST_PAD;
              end else begin
                ctl.init = 1'b1;
                cnt_d    = '0;
                pend_d   = 1'b0;
                xor_d    = 8'h36;
                ret_d    = RET_MSG;
                state_d  = ST_LOADK;
              end
            end
          end
        end else if (in_acc && phase_q == PH_MSG && in_data_i.mode) begin
          if (in_data_i.has_byte) begin
            ctl.put  = 1'b1;
            ctl.cnt  = 1'b1;
            ctl.data = in_data_i.byte_value;
          end
          if (in_data_i.last) begin
            psub_d  = PS_MARK;
            ret_d   = RET_INNERD;
            state_d = ST_PAD;
          end
        end
      end

      ST_LOADK: begin
        if (pend_q) begin
          ctl.put  = 1'b1;
          ctl.cnt  = 1'b1;
          ctl.data = (zero_q ? 8'h00 : km_rd_q) ^ xor_q;
          cnt_d    = cnt_q + 7'd1;
          pend_d   = 1'b0;
        end else if (cnt_q[6]) begin
          case (ret_q)
            RET_PUTB: state_d = ST_PUTB;
            RET_MSG: begin
              phase_d = PH_MSG;
              state_d = ST_IDLE;
            end
            default: begin
              cnt_d   = '0;
              state_d = ST_INNER;
            end
          endcase
        end else if (!stat.busy) begin
          // bytes past the key length read as zero padding
          km_re  = 1'b1;
          zero_d = (cnt_q >= klen_q);
          pend_d = 1'b1;
        end
      end

      ST_PUTB: begin
        if (!stat.busy) begin
          ctl.put  = 1'b1;
          ctl.cnt  = 1'b1;
          ctl.data = item_b_q;
          if (item_last_q) begin
            psub_d  = PS_MARK;
            ret_d   = RET_KEYDIG;
            state_d = ST_PAD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_PAD: begin
        if (!stat.busy) begin
          case (psub_q)
            PS_MARK: begin
              ctl.put  = 1'b1;
              ctl.data = 8'h80;
              psub_d   = PS_ZERO;
            end
            PS_ZERO: begin
              if (stat.fill == 6'd56) begin
                cnt_d  = '0;
                psub_d = PS_LEN;
              end else begin
                ctl.put  = 1'b1;
                ctl.data = 8'h00;
              end
            end
            default: begin
              // bit count is stable here: padding beats are not counted
              ctl.put  = 1'b1;
              ctl.data = 8'(bits >> (6'd56 - {cnt_q[2:0], 3'b000}));
              cnt_d    = cnt_q + 7'd1;
              if (cnt_q[2:0] == 3'd7) state_d = ST_WAITD;
            end
          endcase
        end
      end

      ST_WAITD: begin
        if (!stat.busy) begin
          case (ret_q)
            RET_KEYDIG: begin
              cnt_d   = '0;
              state_d = ST_KEYW;
            end
            RET_INNERD: begin
              inner_d  = h;
              ctl.init = 1'b1;
              cnt_d    = '0;
              pend_d   = 1'b0;
              xor_d    = 8'h5c;
              ret_d    = RET_INNERB;
              state_d  = ST_LOADK;
            end
            RET_TAG: begin
              cnt_d   = '0;
              state_d = ST_OUT;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      ST_KEYW: begin
        km_we = 1'b1;
        km_wa = cnt_q[5:0];
        km_wd = dig_byte(h, cnt_q[4:0]);
        cnt_d = cnt_q + 7'd1;
        if (cnt_q[4:0] == 5'd31) begin
          klen_d   = 7'd32;
          ctl.init = 1'b1;
          cnt_d    = '0;
          pend_d   = 1'b0;
          xor_d    = 8'h36;
          ret_d    = RET_MSG;
          state_d  = ST_LOADK;
        end
      end

      ST_INNER: begin
        if (!stat.busy) begin
          ctl.put  = 1'b1;
          ctl.cnt  = 1'b1;
          ctl.data = dig_byte(inner_q, cnt_q[4:0]);
          cnt_d    = cnt_q + 7'd1;
          if (cnt_q[4:0] == 5'd31) begin
            psub_d  = PS_MARK;
            ret_d   = RET_TAG;
            state_d = ST_PAD;
          end
        end
      end

      ST_OUT: begin
        if (!out_stall_i) begin
          cnt_d = cnt_q + 7'd1;
          if (cnt_q[2:0] == 3'd7) begin
            klen_d   = '0;
            long_d   = 1'b0;
            ctl.init = 1'b1;
            phase_d  = PH_KEY;
            state_d  = ST_IDLE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= RET_PUTB;
      phase_q <= PH_KEY;
      klen_q  <= '0;
      long_q  <= 1'b0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      psub_q  <= PS_MARK;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      phase_q <= phase_d;
      klen_q  <= klen_d;
      long_q  <= long_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      psub_q  <= psub_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q      <= zero_d;
    xor_q       <= xor_d;
    item_b_q    <= item_b_d;
    item_last_q <= item_last_d;
    inner_q     <= inner_d;
  end

  always_ff @(posedge clk_i) begin
    if (km_we) key_mem[km_wa] <= km_wd;
    if (km_re) km_rd_q <= key_mem[cnt_q[5:0]];
  end

  assign out_valid_o            = (state_q == ST_OUT);
  assign out_data_o.digest_word = h[cnt_q[2:0]];
  assign out_data_o.word_index  = cnt_q[2:0];
  assign out_data_o.last_word   = (cnt_q[2:0] == 3'd7);

  `HSE_ASSERT_IMPL(a_out_core_idle, out_valid_o, !stat.busy)
  `HSE_ASSERT_IMPL(a_busy_from_put, $rose(stat.busy), $past(ctl.put))
  `HSE_ASSERT_IMPL(a_klen_range, 1'b1, klen_q <= 7'd64)
  `HSE_ASSERT_NEXT(a_tag_clears_key, out_valid_o && !out_stall_i && out_data_o.last_word,
                   phase_q == PH_KEY && klen_q == 7'd0 && !long_q)

endmodule

FILE: rtl/core/hse_core.sv
`timescale 1ns / 1ps
// SHA-256 byte absorber and one-round-per-cycle compression.
module hse_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hse_pkg::hs_ctl_t  ctl_i,
  output hse_pkg::hs_stat_t stat_o,
  output hse_pkg::hse_words_t h_o,
  output logic [63:0]       bits_o
);
  import hse_pkg::*;

  hse_words_t  h_q, h_d;
  hse_words_t  v_q, v_d;
  logic [31:0] win_q [16];
  logic [31:0] win_d [16];
  logic [23:0] word_q, word_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bits_q, bits_d;
  logic [6:0]  rnd_q, rnd_d;
  logic        busy_q, busy_d;

  logic [31:0] t1, t2, new_w, push_w;
  logic        do_push;

  always_comb begin
    t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
       + round_k(rnd_q[5:0]) + win_q[0];
    t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
    new_w = ssig1(win_q[14]) + win_q[9] + ssig0(win_q[1]) + win_q[0];
  end

  always_comb begin
    h_d    = h_q;
    v_d    = v_q;
    word_d = word_q;
    fill_d = fill_q;
    bits_d = bits_q;
    rnd_d  = rnd_q;
    busy_d = busy_q;
    win_d  = win_q;
    do_push = 1'b0;
    push_w  = new_w;

    if (ctl_i.init) begin
      h_d    = SHA_IV;
      fill_d = '0;
      bits_d = '0;
    end

    if (ctl_i.put) begin
      word_d = {word_q[15:0], ctl_i.data};
      fill_d = fill_q + 6'd1;
      if (ctl_i.cnt) bits_d = bits_q + 64'd8;
      if (fill_q[1:0] == 2'd3) begin
        do_push = 1'b1;
        push_w  = {word_q, ctl_i.data};
      end
      if (fill_q == 6'd63) begin
        busy_d = 1'b1;
        rnd_d  = '0;
        v_d    = h_q;
      end
    end

    if (busy_q) begin
      if (rnd_q[6]) begin
        for (int i = 0; i < 8; i++) h_d[i] = h_q[i] + v_q[i];
        busy_d = 1'b0;
      end else begin
        v_d[7] = v_q[6];
        v_d[6] = v_q[5];
        v_d[5] = v_q[4];
        v_d[4] = v_q[3] + t1;
        v_d[3] = v_q[2];
        v_d[2] = v_q[1];
        v_d[1] = v_q[0];
        v_d[0] = t1 + t2;
        rnd_d  = rnd_q + 7'd1;
        do_push = 1'b1;
      end
    end

    if (do_push) begin
      for (int i = 0; i < 15; i++) win_d[i] = win_q[i + 1];
      win_d[15] = push_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q    <= SHA_IV;
      fill_q <= '0;
      bits_q <= '0;
      rnd_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      h_q    <= h_d;
      fill_q <= fill_d;
      bits_q <= bits_d;
      rnd_q  <= rnd_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    word_q <= word_d;
    win_q  <= win_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.fill = fill_q;
  assign h_o         = h_q;
  assign bits_o      = bits_q;

endmodule

FILE: dv/hmac_sha256_checker.sv
`timescale 1ns / 1ps
module hmac_sha256_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  hse_pkg::hse_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  hse_pkg::hse_out_t out_data_i,
  output int                fail_count_o,
  output int                tag_count_o,
  output int                pending_o
);
  import hse_pkg::*;

  localparam logic PH_KEY = 1'b0;
  localparam logic PH_MSG = 1'b1;

  localparam logic [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  localparam logic [31:0] IV [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
    32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  logic [31:0] h_st [8];
  logic [7:0]  blk [64];
  int          fill;
  logic [63:0] nbits;
  logic [7:0]  key_mem [64];
  int          key_len;
  bit          key_long;
  logic        phase;
  hse_out_t    tag_q [$];
  int          fails;
  int          tags;

  assign fail_count_o = fails;
  assign tag_count_o  = tags;
  assign pending_o    = tag_q.size();

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] wi, t1, t2, a, e;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 0; i < 8; i++) v[i] = h_st[i];
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        wi = w[i];
      end else begin
        a = w[(i-15)&15];
        e = w[(i-2)&15];
        wi = w[i&15] + (ror(a,7) ^ ror(a,18) ^ (a >> 3)) + w[(i-7)&15]
             + (ror(e,17) ^ ror(e,19) ^ (e >> 10));
        w[i&15] = wi;
      end
      t1 = v[7] + (ror(v[4],6) ^ ror(v[4],11) ^ ror(v[4],25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[i] + wi;
      t2 = (ror(v[0],2) ^ ror(v[0],13) ^ ror(v[0],22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) h_st[i] += v[i];
  endtask

  task automatic hash_start();
    for (int i = 0; i < 8; i++) h_st[i] = IV[i];
    fill = 0;
    nbits = '0;
  endtask

  task automatic put_byte(logic [7:0] b);
    blk[fill] = b;
    fill++;
    if (fill == 64) begin
      compress_block();
      fill = 0;
    end
  endtask

  task automatic absorb(logic [7:0] b);
    nbits += 64'd8;
    put_byte(b);
  endtask

  task automatic hash_finish(output logic [31:0] dig [8]);
    logic [63:0] len;
    len = nbits;
    put_byte(8'h80);
    while (fill != 56) put_byte(8'h00);
    for (int i = 0; i < 8; i++) put_byte(len[63-8*i -: 8]);
    for (int i = 0; i < 8; i++) dig[i] = h_st[i];
  endtask

  task automatic clear_key();
    for (int i = 0; i < 64; i++) key_mem[i] = 8'h00;
    key_len = 0;
    key_long = 0;
  endtask

  task automatic predict_tag(hse_in_t it);
    logic [31:0] d [8];
    logic [31:0] inner [8];
    if (phase == PH_KEY) begin
      if (it.mode != 1'b0) return;
      if (it.has_byte) begin
        if (key_long) begin
          absorb(it.byte_value);
        end else if (key_len < 64) begin
          key_mem[key_len] = it.byte_value;
          key_len++;
        end else begin
          key_long = 1;
          hash_start();
          for (int i = 0; i < 64; i++) absorb(key_mem[i]);
          absorb(it.byte_value);
        end
      end
      if (it.last) begin
        if (key_long) begin
          hash_finish(d);
          for (int i = 0; i < 64; i++)
            key_mem[i] = (i < 32) ? d[i/4][31-8*(i%4) -: 8] : 8'h00;
        end
        hash_start();
        for (int i = 0; i < 64; i++) absorb(key_mem[i] ^ 8'h36);
        phase = PH_MSG;
      end
      return;
    end
    if (it.mode != 1'b1) return;
    if (it.has_byte) absorb(it.byte_value);
    if (!it.last) return;
    hash_finish(inner);
    hash_start();
    for (int i = 0; i < 64; i++) absorb(key_mem[i] ^ 8'h5c);
    for (int i = 0; i < 32; i++) absorb(inner[i/4][31-8*(i%4) -: 8]);
    hash_finish(d);
    for (int i = 0; i < 8; i++)
      tag_q.push_back('{digest_word: d[i], word_index: 3'(i), last_word: (i == 7)});
    clear_key();
    hash_start();
    phase = PH_KEY;
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fails++;
  endtask

  initial begin
    fails = 0;
    tags = 0;
    hash_start();
    clear_key();
    phase = PH_KEY;
  end

  always @(posedge clk_i) begin
    hse_out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) predict_tag(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (tag_q.size() == 0) begin
          report("unexpected word", {29'b0, out_data_i.word_index}, 32'b0);
        end else begin
          want = tag_q.pop_front();
          if (out_data_i.digest_word !== want.digest_word)
            report("digest_word", out_data_i.digest_word, want.digest_word);
          if (out_data_i.word_index !== want.word_index)
            report("word_index", 32'(out_data_i.word_index), 32'(want.word_index));
          if (out_data_i.last_word !== want.last_word)
            report("last_word", 32'(out_data_i.last_word), 32'(want.last_word));
          if (want.last_word) tags++;
        end
      end
    end
  end
endmodule

FILE: dv/tb_hmac_sha256_engine.sv
`timescale 1ns / 1ps
module tb_hmac_sha256_engine;
  import hse_pkg::*;

  localparam int WATCHDOG = 20000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  hse_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  hse_out_t out_data;
  int       fails, tags, pending;
  int       idle_pct, stall_pct;
  int       beats_sent;
  int       quiet;

  hmac_sha256_engine dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  hmac_sha256_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .fail_count_o(fails), .tag_count_o(tags), .pending_o(pending)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // receiver stall, redrawn each falling edge
  always @(negedge clk)
    out_stall <= ($urandom_range(99) < stall_pct);

  // watchdog: cycles with no accepted beat on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("watchdog expired");
      $display("status: fail");
      $finish;
    end
  end

  // valid stays up between back-to-back beats; dropped only while idling
  task automatic send(logic mode, logic [7:0] b, logic has, logic lst);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{mode: mode, byte_value: b, has_byte: has, last: lst};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_part(logic mode, int len, bit empty_last);
    for (int i = 0; i < len; i++)
      send(mode, 8'($urandom), 1'b1, (i == len - 1) && !empty_last);
    if (empty_last || len == 0) send(mode, 8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic random_sessions(int n_beats);
    int target, klen, mlen, r;
    target = beats_sent + n_beats;
    while (beats_sent < target) begin
      r = $urandom_range(99);
      if (r < 10) begin
        send(1'($urandom_range(1)), 8'($urandom), 1'($urandom_range(1)),
             1'($urandom_range(1)));
      end else begin
        r = $urandom_range(99);
        klen = (r < 10) ? $urandom_range(65, 80) : (r < 20) ? 64 : $urandom_range(0, 20);
        mlen = ($urandom_range(9) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 12);
        if ($urandom_range(5) == 0) send(1'b1, 8'($urandom), 1'b1, 1'b1);
        send_part(1'b0, klen, $urandom_range(3) == 0);
        if ($urandom_range(5) == 0) send(1'b0, 8'($urandom), 1'b1, 1'b1);
        send_part(1'b1, mlen, $urandom_range(3) == 0);
      end
    end
  endtask

  initial begin
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    idle_pct = 0;
    stall_pct = 0;
    beats_sent = 0;
    quiet = 0;
    rst_n = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: empty key and message, extreme bytes, 64/65-byte keys, ignored beats
    send(1'b1, 8'hff, 1'b1, 1'b1);
    send(1'b0, 8'h00, 1'b0, 1'b1);
    send(1'b0, 8'hff, 1'b1, 1'b1);
    send(1'b1, 8'h00, 1'b0, 1'b1);
    send(1'b0, 8'h00, 1'b1, 1'b1);
    send(1'b1, 8'hff, 1'b1, 1'b0);
    send(1'b1, 8'h00, 1'b1, 1'b1);
    send_part(1'b0, 64, 1'b0);
    send(1'b1, 8'h5a, 1'b0, 1'b1);
    send_part(1'b0, 65, 1'b1);
    send(1'b1, 8'ha5, 1'b1, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 65 : (ph == 3) ? 24 : 0;
      stall_pct = (ph == 2) ? 65 : (ph == 3) ? 24 : 0;
      random_sessions(ph == 0 ? 20 : 30);
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("covered %0d input beats and %0d tags, keys empty to long", beats_sent, tags);
    $display("idle and stall phases run on both channels");
    if (fails == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
